// ===== hw/rtl/ars_pkg.sv =====
// ============================================================================
// ars_pkg: shared definitions of the 8-bit audio resampler
// Field widths, register indexes, reset values and the command and status
// groups that pass between the controller and the datapath.
// ============================================================================
package ars_pkg;

  localparam int PHASE_W    = 18;
  localparam int RATE_W     = 18;
  localparam int SAMPLE_W   = 16;
  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_RATE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEREO      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIXTEEN_BIT = 2'd2;

  // Register values after reset.
  localparam logic [RATE_W-1:0] RATE_RESET    = 18'd32768;
  localparam logic              STEREO_RESET  = 1'b0;
  localparam logic              SIXTEEN_RESET = 1'b1;

  localparam logic [PHASE_W-1:0] PHASE_MAX = 18'h3FFFF;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // latch the converted byte and clear the run count
    logic skip;    // frame gives no byte: drop the phase by one frame
    logic step;    // a byte was taken and more follow: advance the phase
    logic finish;  // the final byte was taken: settle the phase
  } ars_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic phase_ge;  // phase already covers the whole next frame
    logic last;      // the byte now offered ends the run
  } ars_status_t;

endpackage

// ===== hw/rtl/ars_if.sv =====
// ============================================================================
// ars_if: handshake channels of the 8-bit audio resampler
// Input frame channel, result byte channel and configuration write channel,
// each with valid, ready and its payload.
// ============================================================================
interface ars_in_if;
  logic                          valid;
  logic                          ready;
  logic [ars_pkg::SAMPLE_W-1:0]  first_sample;
  logic [ars_pkg::SAMPLE_W-1:0]  second_sample;

  modport source (output valid, output first_sample, output second_sample, input ready);
  modport sink   (input valid, input first_sample, input second_sample, output ready);
endinterface

interface ars_out_if;
  logic                        valid;
  logic                        ready;
  logic [ars_pkg::BYTE_W-1:0]  out_byte;
  logic                        last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

interface ars_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ars_pkg::CFG_IDX_W-1:0]   index;
  logic [ars_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/ars_ctrl.sv =====
// ============================================================================
// ars_ctrl: controller of the 8-bit audio resampler
// Takes one frame at a time, then offers its bytes one per cycle while
// out_ready is high, until the datapath flags the last one.
// ============================================================================
module ars_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  ars_pkg::ars_status_t status,
  output ars_pkg::ars_cmd_t    cmd
);
  import ars_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EMIT = 1'b1;

  logic state_r;
  logic state_nxt;
  logic in_acc;
  logic out_acc;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_EMIT);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd.load = 1'b1;
          if (status.phase_ge) begin
            cmd.skip = 1'b1;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (out_acc) begin
          if (status.last) begin
            cmd.finish = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  // A frame that gives no byte never starts a run.
  a_skip_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && status.phase_ge) |=> (state_r == S_IDLE))
    else $error("skipped frame started a run");

  // The run ends exactly when the last byte is taken.
  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && status.last) |=> (state_r == S_IDLE))
    else $error("run did not end after its last byte");

  // The block either takes a frame or offers a byte, never both at once.
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready != out_valid)
    else $error("input and output sides active together");
`endif

endmodule

// ===== hw/rtl/ars_dp.sv =====
// ============================================================================
// ars_dp: datapath of the 8-bit audio resampler
// Configuration registers, sample conversion, the byte register, the
// resampling phase and the run counter.
// ============================================================================
module ars_dp #(
  parameter int OUTPUT_RATE = 32768,
  parameter int MAX_RUN     = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  input  logic [ars_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ars_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [ars_pkg::SAMPLE_W-1:0]       first_sample,
  input  logic [ars_pkg::SAMPLE_W-1:0]       second_sample,
  input  ars_pkg::ars_cmd_t                  cmd,
  output ars_pkg::ars_status_t               status,
  output logic [ars_pkg::BYTE_W-1:0]         out_byte
);
  import ars_pkg::*;

  localparam int SUM_W = PHASE_W + 2;
  localparam int CNT_W = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
  localparam logic [SUM_W-1:0] RATE_S  = SUM_W'(OUTPUT_RATE);
  localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(MAX_RUN - 1);

  logic [RATE_W-1:0]  rate_r;
  logic               stereo_r;
  logic               sixteen_r;
  logic [BYTE_W-1:0]  byte_r;
  logic [PHASE_W-1:0] phase_r;
  logic [CNT_W-1:0]   count_r;

  // Conversion.
  logic [16:0]        ssum;
  logic [16:0]        sadj;
  logic [15:0]        v16;
  logic [15:0]        sbias;
  logic [7:0]         hi;
  logic [8:0]         usum;
  logic [7:0]         raw;
  logic [7:0]         mapped;

  // Phase arithmetic.
  logic [SUM_W-1:0]   sum;
  logic [SUM_W-1:0]   diff;
  logic [PHASE_W-1:0] phase_fin;
  logic               cap_hit;

  always_comb begin
    ssum  = {first_sample[15], first_sample} + {second_sample[15], second_sample};
    // Halve with truncation toward zero: add one to negative sums first.
    sadj  = ssum + {16'd0, ssum[16]};
    v16   = stereo_r ? sadj[16:1] : first_sample;
    sbias = v16 ^ 16'h8000;
    hi    = sbias[15:8];
    if (sbias[7] && (hi != 8'hFF)) begin
      hi = hi + 8'd1;
    end
    usum  = {1'b0, first_sample[7:0]} + {1'b0, second_sample[7:0]};
    if (sixteen_r) begin
      raw = hi;
    end else if (stereo_r) begin
      raw = usum[8:1];
    end else begin
      raw = first_sample[7:0];
    end
    if (raw < 8'h80) begin
      mapped = 8'h7F - raw;
    end else if (raw == 8'hFF) begin
      mapped = 8'hFE;
    end else begin
      mapped = raw;
    end
  end

  always_comb begin
    sum     = {2'b00, phase_r} + {2'b00, rate_r};
    diff    = sum - RATE_S;
    cap_hit = (count_r == CNT_TOP);
    if (sum < RATE_S) begin
      phase_fin = '0;
    end else if (diff > {2'b00, PHASE_MAX}) begin
      phase_fin = PHASE_MAX;
    end else begin
      phase_fin = diff[PHASE_W-1:0];
    end
  end

  assign status.phase_ge = ({2'b00, phase_r} >= RATE_S);
  assign status.last     = (sum >= RATE_S) || cap_hit;
  assign out_byte        = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r    <= RATE_RESET;
      stereo_r  <= STEREO_RESET;
      sixteen_r <= SIXTEEN_RESET;
      phase_r   <= '0;
      count_r   <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_INPUT_RATE:  rate_r    <= cfg_data[RATE_W-1:0];
          CFG_STEREO:      stereo_r  <= cfg_data[0];
          CFG_SIXTEEN_BIT: sixteen_r <= cfg_data[0];
          default:         ;
        endcase
      end
      if (cmd.load) begin
        count_r <= '0;
      end else if (cmd.step) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (cmd.skip) begin
        phase_r <= PHASE_W'({2'b00, phase_r} - RATE_S);
      end else if (cmd.step) begin
        phase_r <= sum[PHASE_W-1:0];
      end else if (cmd.finish) begin
        phase_r <= phase_fin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_r <= mapped;
    end
  end

`ifndef SYNTHESIS
  // A step is never taken on the last byte of the run.
  a_step_below_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> !cap_hit)
    else $error("run counter stepped past its cap");

  // Inside a run the phase stays below one frame.
  a_step_phase_low: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |=> ({2'b00, phase_r} < RATE_S))
    else $error("phase left the frame in the middle of a run");

  // Every new frame starts its run with a cleared count.
  a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (count_r == '0))
    else $error("run count not cleared by a new frame");
`endif

endmodule

// ===== hw/rtl/audio_resample_to_8bit.sv =====
// ============================================================================
// audio_resample_to_8bit: PCM frame to 8-bit nearest-neighbor resampler
// Converts one- or two-channel 8/16-bit frames to bytes at OUTPUT_RATE.
// ============================================================================
// Usage. Frames enter on in_ch (first_sample, second_sample); each accepted
// word is reduced to one byte (stereo averaged, 16-bit offset and rounded,
// then mapped) and that byte is repeated once for every output tick that
// falls inside the frame, at most MAX_RUN times. The bytes leave on out_ch,
// with last_of_run set on the final byte of the frame. A frame that covers
// no tick gives no word on out_ch. cfg_ch writes input_rate (index 0),
// stereo (1) and sixteen_bit (2); it is always ready and must be used only
// while the block is idle. Other indexes are ignored.
// Timing. The first byte of a frame is offered the cycle after the frame is
// accepted and the following bytes one per cycle while out_ch.ready is high.
// The single phase adder, stepped once per byte taken, sets this rate. A new
// frame is taken only after the last byte of the previous one has left.
// Stall. While out_ch.ready is low the offered byte is held and in_ch stays
// not ready. Reset (rst_n low, synchronous) restores the register defaults
// and clears the phase and the controller; no frame is then in flight.
module audio_resample_to_8bit #(
  parameter int OUTPUT_RATE = 32768,
  parameter int MAX_RUN     = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  ars_in_if.sink     in_ch,
  ars_out_if.source  out_ch,
  ars_cfg_if.sink    cfg_ch
);
  import ars_pkg::*;

  ars_cmd_t    cmd;
  ars_status_t status;

  // Configuration writes complete at once.
  assign cfg_ch.ready = 1'b1;

  ars_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  ars_dp #(
    .OUTPUT_RATE (OUTPUT_RATE),
    .MAX_RUN     (MAX_RUN)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_ch.valid),
    .cfg_index     (cfg_ch.index),
    .cfg_data      (cfg_ch.data),
    .first_sample  (in_ch.first_sample),
    .second_sample (in_ch.second_sample),
    .cmd           (cmd),
    .status        (status),
    .out_byte      (out_ch.out_byte)
  );

  // The last flag is meaningful only while a byte is offered.
  assign out_ch.last_of_run = status.last;

endmodule
